>>> design/sbch_pkg.sv
// ----------------------------------------------------------------------------
// sbch_pkg
// Shared types and constants of the spectrum bar colour and height block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbch_pkg;

  // field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned DIM_W   = 12;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned SUM_W   = 19;

  // frame time reduced once: hi * (2^16 mod 6000) + lo
  localparam int unsigned TMOD_W  = 29;
  localparam int unsigned HUE_W   = 17;

  localparam int unsigned BAR_COUNT_DEF  = 64;
  localparam int unsigned BASS_COUNT_DEF = 8;

  localparam int unsigned PERIOD_MS  = 6000;
  localparam int unsigned WRAP_16    = (1 << 16) % PERIOD_MS;
  localparam int unsigned HUE_FULL   = 92160;
  // hue swept across the whole bar array, 300 degrees
  localparam int unsigned BAR_HUE_RANGE = 76800;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_INDEX_W = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_HEIGHT  = 1'b0,
    REG_CENTRE_LINE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [TMOD_W-1:0] time_part;
    logic [HUE_W-1:0]  hue_off;
    logic [LEVEL_W-1:0] level;
    logic              last;
    logic [SUM_W-1:0]  bass_sum;
  } bar_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

>>> design/spectrum_bar_colour_height.sv
// Spectrum bar colour and height. Each transaction on the input carries one
// bar; one transaction on the output follows for each, in order, with the bar
// height, its top row, an RGB colour from a hue that sweeps with frame time
// and spreads across the bars, and the smoothed bass level after that bar.
// With out_ready held high one bar goes in and one comes out every cycle,
// through the seven-stage back pipeline fed from a two-entry queue. A stalled
// output holds the pipeline, and the queue keeps taking bars until it is full.
// max_height and centre_line are written through cfg_write, cfg_index and
// cfg_data; the user must write them only while no bar is in flight, which
// the block itself does not enforce.
// ----------------------------------------------------------------------------
// spectrum_bar_colour_height
// Top level: configuration registers, front, queue and back pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_bar_colour_height import sbch_pkg::*; #(
  parameter int unsigned BAR_COUNT  = BAR_COUNT_DEF,
  parameter int unsigned BASS_COUNT = BASS_COUNT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]       cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [TIME_W-1:0]      frame_time_ms,
  input  wire logic [INDEX_W-1:0]     bar_index,
  input  wire logic [LEVEL_W-1:0]     level,
  input  wire logic                   last_bar,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [DIM_W-1:0]            bar_height,
  output logic [DIM_W-1:0]            bar_top,
  output logic [CHAN_W-1:0]           red,
  output logic [CHAN_W-1:0]           green,
  output logic [CHAN_W-1:0]           blue,
  output logic [LEVEL_W-1:0]          bass_level
);

  logic [DIM_W-1:0] max_height;
  logic [DIM_W-1:0] centre_line;
  queue_status_t    q_status;
  bar_item_t        push_item;
  bar_item_t        pop_item;
  logic             push;
  logic             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_height  <= '0;
      centre_line <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_HEIGHT:  max_height  <= cfg_data;
        REG_CENTRE_LINE: centre_line <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !q_status.full;

  sbch_front #(
    .BAR_COUNT  (BAR_COUNT),
    .BASS_COUNT (BASS_COUNT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .frame_time_ms (frame_time_ms),
    .bar_index     (bar_index),
    .level         (level),
    .last_bar      (last_bar),
    .q_status      (q_status),
    .push          (push),
    .item          (push_item)
  );

  sbch_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  sbch_back #(
    .BASS_COUNT (BASS_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .max_height  (max_height),
    .centre_line (centre_line),
    .q_status    (q_status),
    .pop_item    (pop_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bar_height  (bar_height),
    .bar_top     (bar_top),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .bass_level  (bass_level)
  );

`ifndef SYNTHESIS
  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_height_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bar_height >= DIM_W'(2))
    else $error("bar height below two");

  // value 1: one channel always at full scale
  a_chan_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red == 8'd255 || green == 8'd255 || blue == 8'd255))
    else $error("no channel at full scale");

  // saturation 218/256: one channel always at the floor
  a_chan_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red == 8'd37 || green == 8'd37 || blue == 8'd37))
    else $error("no channel at the saturation floor");
`endif

endmodule

`default_nettype wire

>>> design/sbch_front.sv
// ----------------------------------------------------------------------------
// sbch_front
// Takes bars in, folds the frame time, looks up the per-bar hue offset and
// keeps the running bass sum, then hands each bar to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sbch_front import sbch_pkg::*; #(
  parameter int unsigned BAR_COUNT  = BAR_COUNT_DEF,
  parameter int unsigned BASS_COUNT = BASS_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [TIME_W-1:0]  frame_time_ms,
  input  wire logic [INDEX_W-1:0] bar_index,
  input  wire logic [LEVEL_W-1:0] level,
  input  wire logic               last_bar,
  input  wire queue_status_t      q_status,
  output logic                    push,
  output bar_item_t               item
);

  logic [HUE_W-1:0]   off_tab [2**INDEX_W];
  logic [SUM_W-1:0]   bass_sum;
  logic [SUM_W-1:0]   bass_sum_next;
  logic [SUM_W:0]     sum_add;
  logic               is_bass;

  // hue offset per index, already wrapped to one turn
  for (genvar i = 0; i < 2**INDEX_W; i++) begin : g_off
    assign off_tab[i] = HUE_W'(((i * BAR_HUE_RANGE) / BAR_COUNT) % HUE_FULL);
  end

  assign push    = in_valid && !q_status.full;
  assign is_bass = (INDEX_W+1)'(bar_index) < (INDEX_W+1)'(BASS_COUNT);
  assign sum_add = {1'b0, bass_sum} + (SUM_W+1)'(level);

  always_comb begin
    if (!is_bass) begin
      bass_sum_next = bass_sum;
    end else if (sum_add[SUM_W]) begin
      bass_sum_next = SUM_MAX;
    end else begin
      bass_sum_next = sum_add[SUM_W-1:0];
    end
  end

  always_comb begin
    item.time_part = TMOD_W'(frame_time_ms[TIME_W-1:16]) * TMOD_W'(WRAP_16)
                     + TMOD_W'(frame_time_ms[15:0]);
    item.hue_off   = off_tab[bar_index];
    item.level     = level;
    item.last      = last_bar;
    item.bass_sum  = bass_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bass_sum <= '0;
    end else if (push) begin
      bass_sum <= last_bar ? '0 : bass_sum_next;
    end
  end

endmodule

`default_nettype wire

>>> design/sbch_queue.sv
// ----------------------------------------------------------------------------
// sbch_queue
// Short first-in first-out queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module sbch_queue import sbch_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire bar_item_t push_item,
  input  wire logic      pop,
  output bar_item_t      pop_item,
  output queue_status_t  status
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  bar_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign pop_item     = slots[rd_ptr];
  assign status.full  = count == CNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/sbch_back.sv
// ----------------------------------------------------------------------------
// sbch_back
// Seven-stage pipeline: height and top, bass smoother, time fold, hue, sector
// split, secondary component and the final colour channels in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbch_back import sbch_pkg::*; #(
  parameter int unsigned BASS_COUNT = BASS_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [DIM_W-1:0]   max_height,
  input  wire logic [DIM_W-1:0]   centre_line,
  input  wire queue_status_t      q_status,
  input  wire bar_item_t          pop_item,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [DIM_W-1:0]        bar_height,
  output logic [DIM_W-1:0]        bar_top,
  output logic [CHAN_W-1:0]       red,
  output logic [CHAN_W-1:0]       green,
  output logic [CHAN_W-1:0]       blue,
  output logic [LEVEL_W-1:0]      bass_level
);

  localparam int unsigned STAGES = 6;

  // time mod 6000 through a reciprocal that is exact for 29-bit values
  localparam int unsigned KV_SHIFT = 42;
  localparam int unsigned KV_W     = 30;
  localparam logic [KV_W-1:0] KV =
    KV_W'(((64'd1 << KV_SHIFT) + 64'(PERIOD_MS) - 64'd1) / 64'(PERIOD_MS));
  localparam int unsigned Q_W = TMOD_W + KV_W - KV_SHIFT;
  localparam int unsigned R_W = 13;

  // base hue = r * 1536 / 100 = r * 384 / 25
  localparam int unsigned BASE_SHIFT = 27;
  localparam int unsigned BASE_K_W   = 31;
  localparam logic [BASE_K_W-1:0] BASE_K =
    BASE_K_W'(64'd384 * (((64'd1 << BASE_SHIFT) + 64'd24) / 64'd25));

  // mean of the bass bars
  localparam int unsigned MEAN_SHIFT = 26;
  localparam int unsigned MEAN_K_W   = 27;
  localparam logic [MEAN_K_W-1:0] MEAN_K =
    MEAN_K_W'(((64'd1 << MEAN_SHIFT) + 64'(BASS_COUNT) - 64'd1) / 64'(BASS_COUNT));
  localparam int unsigned MEAN_W = SUM_W + MEAN_K_W - MEAN_SHIFT;

  localparam int unsigned GLIDE_Q16   = 13107;
  localparam int unsigned GLIDE_W     = 14;
  localparam int unsigned GLIDE_SHIFT = 16;
  localparam int unsigned GP_W        = LEVEL_W + 2 + GLIDE_W;

  localparam int unsigned MIN_HEIGHT = 2;

  localparam int unsigned SECTOR   = 15360;
  localparam int unsigned FRAC_W   = 14;
  localparam int unsigned SAT_Q8   = 218;
  localparam int unsigned X_W      = 22;
  localparam logic [X_W-1:0] FULL_C = X_W'(SAT_Q8 * SECTOR);
  localparam logic [X_W-1:0] FLOOR_M = X_W'((256 - SAT_Q8) * SECTOR);
  localparam int unsigned CHAN_MUL = 17;
  localparam int unsigned CHAN_SHIFT = 18;

  // (comp + m) * 255 / (256 * 15360) = (comp + m) * 17 >> 18
  function automatic logic [CHAN_W-1:0] chan_level(input logic [X_W-1:0] comp);
    logic [X_W-1:0] lifted;
    logic [X_W+4:0] scaled;
    lifted = comp + FLOOR_M;
    scaled = (X_W+5)'(lifted) * (X_W+5)'(CHAN_MUL);
    return scaled[CHAN_SHIFT +: CHAN_W];
  endfunction

  logic                adv;
  logic [STAGES-1:0]   stage_valid;

  logic [DIM_W-1:0]    height_line [STAGES];
  logic [DIM_W-1:0]    top_line    [STAGES];
  logic [LEVEL_W-1:0]  bass_line   [1:STAGES-1];

  // stage 1
  logic [TMOD_W+KV_W-1:0]     q_prod;
  logic [LEVEL_W+DIM_W-1:0]   h_prod;
  logic [DIM_W-1:0]           h_raw;
  logic [DIM_W-1:0]           h_min;
  logic [DIM_W-1:0]           h_half;
  logic [SUM_W+MEAN_K_W-1:0]  m_prod;
  logic [MEAN_W-1:0]          mean_raw;
  logic [TMOD_W-1:0]          time_s1;
  logic [Q_W-1:0]             quot_s1;
  logic [HUE_W-1:0]           off_s1;
  logic                       last_s1;
  logic [LEVEL_W-1:0]         mean_s1;

  // stage 2
  logic [TMOD_W-1:0]          rem_full;
  logic signed [LEVEL_W+1:0]  glide_delta;
  logic signed [GP_W-1:0]     glide_prod;
  logic signed [GP_W-1:0]     smooth_sum;
  logic [LEVEL_W-1:0]         bass_smoothed;
  logic [LEVEL_W-1:0]         bass_smoothed_next;
  logic [R_W-1:0]             rem_s2;
  logic [HUE_W-1:0]           off_s2;

  // stage 3
  logic [R_W+BASE_K_W-1:0]    base_prod;
  logic [HUE_W-1:0]           base_s3;
  logic [HUE_W-1:0]           off_s3;

  // stage 4
  logic [HUE_W:0]             hue_sum;
  logic [HUE_W-1:0]           hue_s4;

  // stage 5
  logic [2:0]                 sector;
  logic [HUE_W-1:0]           frac_wide;
  logic [2:0]                 sector_s5;
  logic [FRAC_W-1:0]          frac_s5;

  // stage 6
  logic [FRAC_W-1:0]          x_frac;
  logic [2:0]                 sector_s6;
  logic [X_W-1:0]             x_s6;

  // output
  logic [X_W-1:0]             comp_r;
  logic [X_W-1:0]             comp_g;
  logic [X_W-1:0]             comp_b;

  assign adv = !out_valid || out_ready;
  assign pop = adv && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else if (adv) begin
      stage_valid <= {stage_valid[STAGES-2:0], pop};
      out_valid   <= stage_valid[STAGES-1];
    end
  end

  // stage 1: height, top, reciprocal for time fold and bass mean
  always_comb begin
    q_prod   = (TMOD_W+KV_W)'(pop_item.time_part) * (TMOD_W+KV_W)'(KV);
    h_prod   = (LEVEL_W+DIM_W)'(pop_item.level) * (LEVEL_W+DIM_W)'(max_height);
    h_raw    = h_prod[LEVEL_W +: DIM_W];
    h_min    = (h_raw < DIM_W'(MIN_HEIGHT)) ? DIM_W'(MIN_HEIGHT) : h_raw;
    h_half   = h_min >> 1;
    m_prod   = (SUM_W+MEAN_K_W)'(pop_item.bass_sum) * (SUM_W+MEAN_K_W)'(MEAN_K);
    mean_raw = m_prod[MEAN_SHIFT +: MEAN_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      time_s1        <= pop_item.time_part;
      quot_s1        <= q_prod[KV_SHIFT +: Q_W];
      off_s1         <= pop_item.hue_off;
      last_s1        <= pop_item.last;
      mean_s1        <= (mean_raw > MEAN_W'({LEVEL_W{1'b1}})) ? '1
                                                               : mean_raw[LEVEL_W-1:0];
    end
  end

  // stage 2: remainder of the time fold, bass smoother
  always_comb begin
    rem_full    = time_s1 - TMOD_W'(quot_s1) * TMOD_W'(PERIOD_MS);
    glide_delta = $signed({2'b00, mean_s1}) - $signed({2'b00, bass_smoothed});
    glide_prod  = GP_W'(glide_delta) * $signed(GP_W'(GLIDE_Q16));
    // arithmetic shift floors toward minus infinity
    smooth_sum  = $signed(GP_W'(bass_smoothed)) + (glide_prod >>> GLIDE_SHIFT);
    if (smooth_sum[GP_W-1]) begin
      bass_smoothed_next = '0;
    end else if (|smooth_sum[GP_W-2:LEVEL_W]) begin
      bass_smoothed_next = '1;
    end else begin
      bass_smoothed_next = smooth_sum[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bass_smoothed <= '0;
    end else if (adv && stage_valid[0] && last_s1) begin
      bass_smoothed <= bass_smoothed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_s2       <= rem_full[R_W-1:0];
      off_s2       <= off_s1;
    end
  end

  // stage 3: base hue of the frame
  assign base_prod = (R_W+BASE_K_W)'(rem_s2) * (R_W+BASE_K_W)'(BASE_K);

  always_ff @(posedge clk) begin
    if (adv) begin
      base_s3 <= base_prod[BASE_SHIFT +: HUE_W];
      off_s3  <= off_s2;
    end
  end

  // stage 4: hue wrapped to one turn
  assign hue_sum = (HUE_W+1)'(base_s3) + (HUE_W+1)'(off_s3);

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_s4 <= (hue_sum >= (HUE_W+1)'(HUE_FULL)) ? HUE_W'(hue_sum - (HUE_W+1)'(HUE_FULL))
                                                  : hue_sum[HUE_W-1:0];
    end
  end

  // stage 5: sector and offset within it
  always_comb begin
    sector = '0;
    for (int k = 1; k < 6; k++) begin
      if (hue_s4 >= HUE_W'(k * SECTOR)) begin
        sector = 3'(k);
      end
    end
    frac_wide = hue_s4 - HUE_W'(sector) * HUE_W'(SECTOR);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sector_s5 <= sector;
      frac_s5   <= frac_wide[FRAC_W-1:0];
    end
  end

  // stage 6: rising or falling secondary component
  assign x_frac = sector_s5[0] ? FRAC_W'(SECTOR) - frac_s5 : frac_s5;

  always_ff @(posedge clk) begin
    if (adv) begin
      sector_s6 <= sector_s5;
      x_s6      <= X_W'(x_frac) * X_W'(SAT_Q8);
    end
  end

  // output register: colour channels
  always_comb begin
    case (sector_s6)
      3'd0: begin
        comp_r = FULL_C; comp_g = x_s6;   comp_b = '0;
      end
      3'd1: begin
        comp_r = x_s6;   comp_g = FULL_C; comp_b = '0;
      end
      3'd2: begin
        comp_r = '0;     comp_g = FULL_C; comp_b = x_s6;
      end
      3'd3: begin
        comp_r = '0;     comp_g = x_s6;   comp_b = FULL_C;
      end
      3'd4: begin
        comp_r = x_s6;   comp_g = '0;     comp_b = FULL_C;
      end
      default: begin
        comp_r = FULL_C; comp_g = '0;     comp_b = x_s6;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // height and top enter at stage 1, bass level at stage 2
      height_line[0] <= h_min;
      top_line[0]    <= (centre_line > h_half) ? centre_line - h_half : '0;
      bass_line[1]   <= last_s1 ? bass_smoothed_next : bass_smoothed;
      for (int s = 1; s < STAGES; s++) begin
        height_line[s] <= height_line[s-1];
        top_line[s]    <= top_line[s-1];
      end
      for (int s = 2; s < STAGES; s++) begin
        bass_line[s] <= bass_line[s-1];
      end
      bar_height <= height_line[STAGES-1];
      bar_top    <= top_line[STAGES-1];
      bass_level <= bass_line[STAGES-1];
      red        <= chan_level(comp_r);
      green      <= chan_level(comp_g);
      blue       <= chan_level(comp_b);
    end
  end

endmodule

`default_nettype wire

>>> tb/bar_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// bar_scoreboard_pkg
// Predicts the height, top row, colour and bass level of each spectrum bar
// and checks the block's results against them in order.
// ----------------------------------------------------------------------------
package bar_scoreboard_pkg;

  import sbch_pkg::*;

  class bar_scoreboard;

    typedef struct {
      logic [DIM_W-1:0]   height;
      logic [DIM_W-1:0]   top;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [LEVEL_W-1:0] bass;
    } bar_result_t;

    localparam int unsigned SECTOR = 15360;
    localparam int unsigned SAT    = 218;
    localparam longint      GLIDE  = 13107;

    logic [DIM_W-1:0]   max_height;
    logic [DIM_W-1:0]   centre_line;
    logic [SUM_W-1:0]   bass_sum;
    logic [LEVEL_W-1:0] bass_smoothed;
    bar_result_t        pending[$];
    int unsigned        errors;
    int unsigned        bars_in;
    int unsigned        bars_checked;
    int unsigned        frame_ends;
    int unsigned        reg_writes;

    function new();
      max_height    = '0;
      centre_line   = '0;
      bass_sum      = '0;
      bass_smoothed = '0;
      errors        = 0;
      bars_in       = 0;
      bars_checked  = 0;
      frame_ends    = 0;
      reg_writes    = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [DIM_W-1:0] value);
      reg_writes++;
      case (idx)
        REG_MAX_HEIGHT:  max_height  = value;
        REG_CENTRE_LINE: centre_line = value;
        default: ;
      endcase
    endfunction

    // component scaled by 15360 plus the white floor, down to 8 bits
    function logic [CHAN_W-1:0] to_channel(int unsigned comp);
      longint unsigned scaled;
      scaled = (longint'(comp) + longint'((256 - SAT) * SECTOR)) * 255;
      return CHAN_W'(scaled / (256 * SECTOR));
    endfunction

    function void note_bar(logic [TIME_W-1:0] t, logic [INDEX_W-1:0] idx,
                           logic [LEVEL_W-1:0] lvl, logic last);
      bar_result_t res;
      int unsigned h, half, tmod, hue, sector, frac, c, x, r, g, b, mean;
      longint      delta, step, ns;
      h = (int'(lvl) * int'(max_height)) >> 16;
      if (h < 2) h = 2;
      half = h >> 1;
      res.height = DIM_W'(h);
      res.top    = (centre_line > half) ? DIM_W'(centre_line - half) : '0;

      tmod   = t % PERIOD_MS;
      hue    = (tmod * 1536) / 100 + (int'(idx) * BAR_HUE_RANGE) / BAR_COUNT_DEF;
      hue    = hue % HUE_FULL;
      sector = hue / SECTOR;
      frac   = hue % SECTOR;
      c      = SAT * SECTOR;
      x      = sector[0] ? SAT * (SECTOR - frac) : SAT * frac;
      case (sector)
        0:       begin r = c; g = x; b = 0; end
        1:       begin r = x; g = c; b = 0; end
        2:       begin r = 0; g = c; b = x; end
        3:       begin r = 0; g = x; b = c; end
        4:       begin r = x; g = 0; b = c; end
        default: begin r = c; g = 0; b = x; end
      endcase
      res.red   = to_channel(r);
      res.green = to_channel(g);
      res.blue  = to_channel(b);

      if (idx < BASS_COUNT_DEF) begin
        if (int'(bass_sum) + int'(lvl) > int'(SUM_MAX)) bass_sum = SUM_MAX;
        else bass_sum = bass_sum + lvl;
      end
      if (last) begin
        mean = bass_sum / BASS_COUNT_DEF;
        if (mean > 65535) mean = 65535;
        delta = longint'(mean) - longint'(bass_smoothed);
        // arithmetic shift floors toward minus infinity
        step = (delta * GLIDE) >>> 16;
        ns = longint'(bass_smoothed) + step;
        if (ns < 0) ns = 0;
        if (ns > 65535) ns = 65535;
        bass_smoothed = LEVEL_W'(ns);
        bass_sum = '0;
        frame_ends++;
      end
      res.bass = bass_smoothed;
      pending.push_back(res);
      bars_in++;
    endfunction

    function void check_result(logic [DIM_W-1:0] height, logic [DIM_W-1:0] top,
                               logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                               logic [CHAN_W-1:0] blue, logic [LEVEL_W-1:0] bass);
      bar_result_t exp;
      if (pending.size() == 0) begin
        $error("result transaction with no bar waiting: height %0d top %0d", height, top);
        errors++;
        return;
      end
      exp = pending.pop_front();
      bars_checked++;
      if (height !== exp.height) begin
        $error("bar_height: expected %0d, actual %0d", exp.height, height);
        errors++;
      end
      if (top !== exp.top) begin
        $error("bar_top: expected %0d, actual %0d", exp.top, top);
        errors++;
      end
      if (red !== exp.red) begin
        $error("red: expected %0d, actual %0d", exp.red, red);
        errors++;
      end
      if (green !== exp.green) begin
        $error("green: expected %0d, actual %0d", exp.green, green);
        errors++;
      end
      if (blue !== exp.blue) begin
        $error("blue: expected %0d, actual %0d", exp.blue, blue);
        errors++;
      end
      if (bass !== exp.bass) begin
        $error("bass_level: expected %0d, actual %0d", exp.bass, bass);
        errors++;
      end
    endfunction

  endclass

endpackage

>>> tb/spectrum_bar_colour_height_test.sv
// ----------------------------------------------------------------------------
// spectrum_bar_colour_height_test
// Streams spectrum bars through the block under several register settings
// and handshake timings, predicting every result and checking it in order.
// ----------------------------------------------------------------------------
module spectrum_bar_colour_height_test;

  timeunit 1ns;
  timeprecision 1ps;

  import sbch_pkg::*;
  import bar_scoreboard_pkg::*;

  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned STALL_LIMIT = 1000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [TIME_W-1:0]      frame_time_ms = '0;
  logic [INDEX_W-1:0]     bar_index = '0;
  logic [LEVEL_W-1:0]     level = '0;
  logic                   last_bar = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [DIM_W-1:0]       bar_height;
  logic [DIM_W-1:0]       bar_top;
  logic [CHAN_W-1:0]      red;
  logic [CHAN_W-1:0]      green;
  logic [CHAN_W-1:0]      blue;
  logic [LEVEL_W-1:0]     bass_level;

  bar_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  spectrum_bar_colour_height u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .frame_time_ms (frame_time_ms),
    .bar_index     (bar_index),
    .level         (level),
    .last_bar      (last_bar),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .bar_height    (bar_height),
    .bar_top       (bar_top),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .bass_level    (bass_level)
  );

  always #4 clk = ~clk;

  // monitor: register writes and both transaction sides at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) begin
        sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      end
      if (in_valid && in_ready) begin
        sb.note_bar(frame_time_ms, bar_index, level, last_bar);
      end
      if (out_valid && out_ready) begin
        sb.check_result(bar_height, bar_top, red, green, blue, bass_level);
      end
      if (cfg_write || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("no transaction for %0d cycles", STALL_LIMIT);
    $display("FAIL spectrum_bar_colour_height");
    $finish;
  end

  // called and returns at a falling edge
  task automatic send_bar(input logic [TIME_W-1:0] t, input logic [INDEX_W-1:0] idx,
                          input logic [LEVEL_W-1:0] lvl, input logic last);
    int unsigned gap;
    gap = 0;
    // each cycle idles with the set probability
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    frame_time_ms <= t;
    bar_index     <= idx;
    level         <= lvl;
    last_bar      <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [DIM_W-1:0] height, input logic [DIM_W-1:0] centre);
    stop_sending();
    wait_drained();
    write_reg(REG_MAX_HEIGHT, height);
    write_reg(REG_CENTRE_LINE, centre);
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    if ($urandom_range(1) == 0) return TIME_W'($urandom_range(20000));
    return $urandom;
  endfunction

  // mostly whole frames with random content, the rest loose bars
  task automatic send_frames(input int unsigned count);
    int unsigned done, nbars;
    logic [TIME_W-1:0] t;
    done = 0;
    while (done < count) begin
      if ($urandom_range(99) < 80) begin
        nbars = ($urandom_range(9) == 0) ? BAR_COUNT_DEF : $urandom_range(1, 16);
        t = pick_time();
        for (int unsigned i = 0; i < nbars; i++)
          send_bar(t, INDEX_W'(i), pick_level(), i == nbars - 1);
        done += nbars;
      end else begin
        send_bar(pick_time(), INDEX_W'($urandom), pick_level(), 1'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // registers still at reset: every bar is the minimum height
    send_bar(32'd0, 6'd0, 16'hFFFF, 1'b0);
    send_bar(32'hFFFF_FFFF, 6'd63, 16'h0000, 1'b1);

    set_regs(12'd4095, 12'd100);
    send_bar(32'd5999, 6'd0, 16'h0000, 1'b0);
    send_bar(32'd6000, 6'd1, 16'hFFFF, 1'b0);
    // each second of the period starts a new colour sector; full levels
    // on repeated bass bars drive the sum into saturation
    for (int unsigned k = 0; k < 8; k++)
      send_bar(TIME_W'((k % 6) * 1000), INDEX_W'((k + 2) % 8), 16'hFFFF, 1'b0);
    send_bar(32'd3000, 6'd40, 16'h8000, 1'b1);
    send_bar(32'h8000_0000, 6'd32, 16'h0001, 1'b1);
    send_bar(32'd500, 6'd8, 16'hFFFF, 1'b0);
    send_bar(32'd12345, 6'd63, 16'h0000, 1'b0);
    send_bar(32'd4321, 6'd7, 16'h7FFF, 1'b1);

    set_regs(12'd4095, 12'd4095);
    send_bar(32'd0, 6'd0, 16'hFFFF, 1'b1);
    send_bar(32'd1, 6'd63, 16'h0000, 1'b0);

    // random part, one timing style per register setting
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_frames(110);

    set_regs(12'd0, 12'd0);
    send_idle_pct = 46;
    recv_stall_pct = 0;
    send_frames(110);

    set_regs(DIM_W'($urandom), DIM_W'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 46;
    send_frames(110);

    set_regs(12'd1, DIM_W'($urandom));
    send_idle_pct = 37;
    recv_stall_pct = 37;
    send_frames(110);

    // long output hold while bars keep coming, so the input backs up
    set_regs(DIM_W'($urandom), 12'd2048);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    send_frames(45);
    stop_sending();
    wait_drained();
    send_frames(65);

    stop_sending();
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("%0d bars sent, %0d results checked, %0d frame ends updated the bass level",
             sb.bars_in, sb.bars_checked, sb.frame_ends);
    $display("%0d register writes; timings: free flow, sender gaps, receiver stalls, both, long hold",
             sb.reg_writes);
    if (sb.errors == 0) begin
      $display("PASS spectrum_bar_colour_height");
    end else begin
      $display("FAIL spectrum_bar_colour_height");
    end
    $finish;
  end

endmodule

>>> sim.f
design/sbch_pkg.sv
design/sbch_front.sv
design/sbch_queue.sv
design/sbch_back.sv
design/spectrum_bar_colour_height.sv
tb/bar_scoreboard_pkg.sv
tb/spectrum_bar_colour_height_test.sv
